// ----- rtl/fbe_pkg.sv -----
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared constants and types for the feedback echo delay block.
// ----------------------------------------------------------------------------
package fbe_pkg;

   // echo store
   localparam int BUF_DEPTH = 131072;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int DELAY_W   = 17;
   localparam int CMP_W     = ((DELAY_W > ADDR_W) ? DELAY_W : ADDR_W) + 1;

   // mix arithmetic: 7*x + 3*d spans +-327680, divide by ten via reciprocal
   // ceil(2^22 / 10) stays exact for magnitudes below 699050
   localparam int SUM_W       = SAMPLE_W + 4;
   localparam int MAG_W       = SUM_W - 1;
   localparam int RECIP_W     = 19;
   localparam int RECIP       = 419431;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W      = MAG_W + RECIP_W;

   // configuration registers
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = DELAY_W;
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(44100);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DELAY_SAMPLES = 1'b0,
      REG_ENABLE        = 1'b1
   } csr_index_type;

endpackage

// ----- rtl/fbe_ram.sv -----
// ----------------------------------------------------------------------------
// fbe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read and a write to the same address at one edge return the old data.
// ----------------------------------------------------------------------------
module fbe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/feedback_echo_delay.sv -----
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Feedback echo on a stream of signed 16-bit samples: each output is
// (7*in + 3*delayed) / 10, truncated toward zero, and is written back into a
// circular echo store that the next samples read.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready   req_tdata  : sample_in
//  rsp      out        rsp_tvalid/rsp_tready   rsp_tdata  : sample_out
//  csr      in         csr_we                  csr_index, csr_wdata
//
//  one sample per cycle unless a stalled result or a pending write-back holds
//  the input; each result passes read, mix and reciprocal multiply into the
//  output register. with a delay of 1 to 3 samples an input waits until the
//  sample whose result it reads has been written back to the echo store.
//  synchronous reset; no clearing pass: entries not yet written since reset
//  read as zero through the write-position wrap flag.
//  a stalled result holds the whole pipeline; while disabled, inputs are
//  taken and dropped.
// ----------------------------------------------------------------------------
module feedback_echo_delay (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fbe_pkg::SAMPLE_W-1:0]   req_tdata,   // [15:0] sample_in
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fbe_pkg::SAMPLE_W-1:0]   rsp_tdata,   // [15:0] sample_out
   input  logic                           csr_we,
   input  logic [fbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbe_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int AW  = fbe_pkg::ADDR_W;
   localparam int SW  = fbe_pkg::SAMPLE_W;
   localparam int AW1 = AW + 1;

   // configuration
   logic [fbe_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic                        enable_ff, enable_in;

   // write position and wrap flag
   logic [AW-1:0] pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;

   // pipeline stages
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_zero_ff;
   logic [SW-1:0]                   s1_x_ff;
   logic [AW-1:0]                   s1_pos_ff;
   logic                            s2_valid_ff, s2_valid_in;
   logic                            s2_neg_ff;
   logic [fbe_pkg::MAG_W-1:0]       s2_mag_ff;
   logic [AW-1:0]                   s2_pos_ff;
   logic                            s3_valid_ff, s3_valid_in;
   logic                            s3_neg_ff;
   logic [fbe_pkg::PROD_W-1:0]      s3_prod_ff;
   logic [AW-1:0]                   s3_pos_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                   rsp_data_ff;

   // datapath
   logic                            adv;
   logic                            hazard;
   logic                            take;
   logic [fbe_pkg::CMP_W-1:0]       delay_ext;
   logic [AW-1:0]                   delay_cl;
   logic [AW1-1:0]                  rd_wide;
   logic [AW-1:0]                   rd_addr;
   logic                            rd_written;
   logic [SW-1:0]                   ram_rd_data;
   logic signed [fbe_pkg::SUM_W-1:0] x_ext, d_ext, sum;
   logic [fbe_pkg::SUM_W-1:0]       sum_abs;
   logic [fbe_pkg::PROD_W-1:0]      prod;
   logic [SW-1:0]                   quot;
   logic [SW-1:0]                   mix_result;

   // ------------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------------
   always_comb begin
      delay_in  = delay_ff;
      enable_in = enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            fbe_pkg::REG_DELAY_SAMPLES: delay_in  = csr_wdata[fbe_pkg::DELAY_W-1:0];
            fbe_pkg::REG_ENABLE:        enable_in = csr_wdata[0];
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // read address and hazard check
   // ------------------------------------------------------------------------
   assign adv = !rsp_valid_ff || rsp_tready;

   always_comb begin
      delay_ext = fbe_pkg::CMP_W'(delay_ff);
      if (delay_ext > fbe_pkg::CMP_W'(fbe_pkg::BUF_DEPTH - 1)) begin
         delay_cl = AW'(fbe_pkg::BUF_DEPTH - 1);
      end else begin
         delay_cl = delay_ext[AW-1:0];
      end
      if (pos_ff >= delay_cl) begin
         rd_wide = AW1'(pos_ff) - AW1'(delay_cl);
      end else begin
         rd_wide = AW1'(pos_ff) + AW1'(fbe_pkg::BUF_DEPTH) - AW1'(delay_cl);
      end
      rd_addr    = rd_wide[AW-1:0];
      // before the first wrap only entries below the write position hold data
      rd_written = wrapped_ff || (rd_addr < pos_ff);
   end

   // entry still waiting for its write-back
   assign hazard = (s1_valid_ff && s1_pos_ff == rd_addr) ||
                   (s2_valid_ff && s2_pos_ff == rd_addr) ||
                   (s3_valid_ff && s3_pos_ff == rd_addr);

   assign req_tready = !enable_ff || (adv && !hazard);
   assign take       = req_tvalid && req_tready && enable_ff;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (take) begin
         if (pos_ff == AW'(fbe_pkg::BUF_DEPTH - 1)) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end
   end

   fbe_ram #(
      .WIDTH (SW),
      .DEPTH (fbe_pkg::BUF_DEPTH)
   ) u_echo_store (
      .clock   (clock),
      .wr_en   (adv && s3_valid_ff),
      .wr_addr (s3_pos_ff),
      .wr_data (mix_result),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // mix arithmetic
   // ------------------------------------------------------------------------
   always_comb begin
      x_ext = fbe_pkg::SUM_W'(signed'(s1_x_ff));
      d_ext = s1_zero_ff ? '0 : fbe_pkg::SUM_W'(signed'(ram_rd_data));
      sum   = (x_ext <<< 3) - x_ext + (d_ext <<< 1) + d_ext;
      sum_abs = sum[fbe_pkg::SUM_W-1] ? fbe_pkg::SUM_W'(-sum) : fbe_pkg::SUM_W'(sum);
   end

   assign prod = fbe_pkg::PROD_W'(s2_mag_ff) * fbe_pkg::PROD_W'(fbe_pkg::RECIP);

   // truncation toward zero: divide the magnitude, then restore the sign
   assign quot       = s3_prod_ff[fbe_pkg::RECIP_SHIFT +: SW];
   assign mix_result = s3_neg_ff ? (~quot + SW'(1)) : quot;

   // ------------------------------------------------------------------------
   // stage control
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = adv ? take        : s1_valid_ff;
      s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = adv ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = adv ? s3_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= fbe_pkg::DELAY_RESET;
         enable_ff    <= 1'b0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         enable_ff    <= enable_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_x_ff    <= req_tdata;
         s1_zero_ff <= !rd_written;
         s1_pos_ff  <= pos_ff;
      end
      if (adv) begin
         s2_neg_ff   <= sum[fbe_pkg::SUM_W-1];
         s2_mag_ff   <= sum_abs[fbe_pkg::MAG_W-1:0];
         s2_pos_ff   <= s1_pos_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_prod_ff  <= prod;
         s3_pos_ff   <= s2_pos_ff;
         rsp_data_ff <= mix_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_read_of_pending_write: assert property (@(posedge clock) disable iff (reset)
      (take && adv && s3_valid_ff) |-> (rd_addr != s3_pos_ff))
      else $error("read of an entry whose write-back is pending");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrap flag cleared outside reset");

   a_pos_only_on_transfer: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(pos_ff))
      else $error("write position moved without a transfer");

   a_stages_distinct: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_pos_ff != s2_pos_ff))
      else $error("two stages carry the same store position");

endmodule

// ----- dv/feedback_echo_delay_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_tb
// Self-checking bench for the feedback echo: a directed table of corner
// samples and register writes, then random phases with fresh delay and
// enable settings, including a long output stall that backs up the input.
// Every result is compared with an in-bench model of the mix and the store, or with a fixed table value.
// ----------------------------------------------------------------------------
module feedback_echo_delay_tb;

   localparam int     CLOCK_PERIOD  = 12;
   localparam int     RESET_CYCLES  = 9;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     RANDOM_ITEMS  = 1000;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     HOLD_PHASE    = 3;
   localparam longint CYCLE_LIMIT   = 1_000_000;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_SAMPLE
   } row_kind_type;

   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_NONE,
      EXP_VALUE
   } exp_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      fbe_pkg::csr_index_type        index;
      logic [fbe_pkg::CSR_W-1:0]     data;
      exp_kind_type                  check;
      logic [fbe_pkg::SAMPLE_W-1:0]  want;
   } echo_row_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [fbe_pkg::SAMPLE_W-1:0] req_tdata  = '0;   // [15:0] sample_in
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [fbe_pkg::SAMPLE_W-1:0] rsp_tdata;         // [15:0] sample_out
   logic                         csr_we     = 1'b0;
   fbe_pkg::csr_index_type       csr_index  = fbe_pkg::REG_DELAY_SAMPLES;
   logic [fbe_pkg::CSR_W-1:0]    csr_wdata  = '0;

   // model of the block
   logic [fbe_pkg::SAMPLE_W-1:0] echo_copy [fbe_pkg::BUF_DEPTH];
   int unsigned                  write_ptr;
   logic [fbe_pkg::DELAY_W-1:0]  delay_reg;
   logic                         enable_reg;

   logic [fbe_pkg::SAMPLE_W-1:0] mix_expected [$];
   echo_row_type                 directed_plan [25];
   int unsigned                  enabled_count = 0;
   int                           mismatch_count = 0;
   longint                       cycle_count = 0;
   bit                           hold_request = 1'b0;

   feedback_echo_delay u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL feedback_echo_delay");
         $finish;
      end
   end

   // one sample through the echo model; the 17-bit delay never exceeds depth-1
   task automatic apply_sample(input logic [fbe_pkg::SAMPLE_W-1:0] x_in,
                               output bit produced,
                               output logic [fbe_pkg::SAMPLE_W-1:0] mixed);
      int unsigned rd_ptr;
      int          mix_sum;
      produced = enable_reg;
      mixed    = '0;
      if (enable_reg) begin
         // zero delay lands on the write slot, i.e. a full store back
         rd_ptr  = (write_ptr + fbe_pkg::BUF_DEPTH - delay_reg) % fbe_pkg::BUF_DEPTH;
         mix_sum = 7 * int'($signed(x_in)) + 3 * int'($signed(echo_copy[rd_ptr]));
         mixed   = fbe_pkg::SAMPLE_W'(mix_sum / 10);
         echo_copy[write_ptr] = mixed;
         write_ptr = (write_ptr + 1) % fbe_pkg::BUF_DEPTH;
         enabled_count++;
      end
   endtask

   task automatic send_sample(input logic [fbe_pkg::SAMPLE_W-1:0] value, input bit eager,
                              input exp_kind_type check,
                              input logic [fbe_pkg::SAMPLE_W-1:0] want);
      int                           gap;
      bit                           produced;
      logic [fbe_pkg::SAMPLE_W-1:0] mixed;
      gap = eager ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      apply_sample(value, produced, mixed);
      case (check)
         EXP_MODEL: if (produced) mix_expected.push_back(mixed);
         EXP_VALUE: mix_expected.push_back(want);
         default: ;
      endcase
   endtask

   task automatic write_csr(input fbe_pkg::csr_index_type index,
                            input logic [fbe_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         fbe_pkg::REG_DELAY_SAMPLES: delay_reg = value[fbe_pkg::DELAY_W-1:0];
         fbe_pkg::REG_ENABLE:        enable_reg = value[0];
         default: ;
      endcase
   endtask

   // dropped samples leave nothing to wait for, so allow the pipeline to empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [fbe_pkg::SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return fbe_pkg::SAMPLE_W'($urandom_range(0, 40) - 20);
         default: return fbe_pkg::SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [fbe_pkg::DELAY_W-1:0] random_delay();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return fbe_pkg::DELAY_W'($urandom_range(1, 3));
         2: return fbe_pkg::DELAY_W'($urandom_range(4, 64));
         3: return fbe_pkg::DELAY_W'(fbe_pkg::BUF_DEPTH - 1);
         default: return fbe_pkg::DELAY_W'($urandom_range(0, fbe_pkg::BUF_DEPTH - 1));
      endcase
   endfunction

   initial begin : result_sink
      int                           gap;
      int                           eager_left;
      bit                           eager;
      logic [fbe_pkg::SAMPLE_W-1:0] want;
      eager_left = 0;
      eager      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (eager_left == 0) begin
            eager      = ($urandom_range(0, 3) == 0);
            eager_left = $urandom_range(10, 60);
         end
         eager_left--;
         gap = eager ? 0 : $urandom_range(0, 10);
         if (hold_request) begin
            gap          = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (mix_expected.size() == 0) begin
            mismatch_count++;
            $error("sample_out: expected no transfer, actual %0d", $signed(rsp_tdata));
         end else begin
            want = mix_expected.pop_front();
            if (rsp_tdata !== want) begin
               mismatch_count++;
               $error("sample_out: expected %0d, actual %0d",
                      $signed(want), $signed(rsp_tdata));
            end
         end
      end
   end

   initial begin : stimulus
      int                        phase;
      int                        burst;
      bit                        eager;
      logic [fbe_pkg::CSR_W-1:0] word;
      int unsigned               random_start;

      foreach (echo_copy[i]) echo_copy[i] = '0;
      write_ptr  = 0;
      delay_reg  = fbe_pkg::DELAY_RESET;
      enable_reg = 1'b0;

      directed_plan = '{
         // disabled out of reset: dropped
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h003E8, EXP_NONE,  16'd0},
         '{ROW_WRITE,  fbe_pkg::REG_DELAY_SAMPLES, 17'd5,     EXP_NONE,  16'd0},
         '{ROW_WRITE,  fbe_pkg::REG_ENABLE,        17'd1,     EXP_NONE,  16'd0},
         // fresh store reads zero
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h07FFF, EXP_VALUE, 16'd22936},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h08000, EXP_VALUE, 16'(-22937)},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h00000, EXP_VALUE, 16'd0},
         // small magnitudes truncate toward zero
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h0FFFF, EXP_VALUE, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h00001, EXP_VALUE, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h07FFF, EXP_MODEL, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h08000, EXP_MODEL, 16'd0},
         // only bit 0 of the enable write counts
         '{ROW_WRITE,  fbe_pkg::REG_ENABLE,        17'd2,     EXP_NONE,  16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h01234, EXP_NONE,  16'd0},
         '{ROW_WRITE,  fbe_pkg::REG_ENABLE,        17'd3,     EXP_NONE,  16'd0},
         // shortest feedback loop
         '{ROW_WRITE,  fbe_pkg::REG_DELAY_SAMPLES, 17'd1,     EXP_NONE,  16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h08000, EXP_MODEL, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h08000, EXP_MODEL, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h07FFF, EXP_MODEL, 16'd0},
         // zero delay reads a full store back, still unwritten
         '{ROW_WRITE,  fbe_pkg::REG_DELAY_SAMPLES, 17'd0,     EXP_NONE,  16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h07FFF, EXP_VALUE, 16'd22936},
         '{ROW_WRITE,  fbe_pkg::REG_DELAY_SAMPLES, 17'h1FFFF, EXP_NONE,  16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h08000, EXP_VALUE, 16'(-22937)},
         '{ROW_WRITE,  fbe_pkg::REG_DELAY_SAMPLES, 17'd2,     EXP_NONE,  16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h04321, EXP_MODEL, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h0BCDE, EXP_MODEL, 16'd0},
         '{ROW_SAMPLE, fbe_pkg::REG_DELAY_SAMPLES, 17'h00800, EXP_MODEL, 16'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            settle();
            write_csr(directed_plan[i].index, directed_plan[i].data);
         end else begin
            send_sample(directed_plan[i].data[fbe_pkg::SAMPLE_W-1:0], 1'b0,
                        directed_plan[i].check, directed_plan[i].want);
         end
      end

      random_start = enabled_count;
      phase = 0;
      while (enabled_count - random_start < RANDOM_ITEMS) begin
         phase++;
         settle();
         // random upper bits in the enable write must be ignored
         word    = fbe_pkg::CSR_W'($urandom());
         word[0] = (phase == HOLD_PHASE || $urandom_range(0, 5) != 0);
         write_csr(fbe_pkg::REG_DELAY_SAMPLES, random_delay());
         write_csr(fbe_pkg::REG_ENABLE, word);
         burst = $urandom_range(10, 60);
         eager = ($urandom_range(0, 3) == 0);
         if (phase == HOLD_PHASE) begin
            // long output stall while the input keeps offering
            burst        = 100;
            eager        = 1'b1;
            hold_request = 1'b1;
         end
         repeat (burst) send_sample(random_sample(), eager, EXP_MODEL, '0);
      end

      settle();
      if (mismatch_count == 0)
         $display("PASS feedback_echo_delay");
      else
         $display("FAIL feedback_echo_delay");
      $finish;
   end

endmodule

// ----- feedback_echo_delay.f -----
rtl/fbe_pkg.sv
rtl/fbe_ram.sv
rtl/feedback_echo_delay.sv
dv/feedback_echo_delay_tb.sv
